// ===== hw/rtl/otlpq_pkg.sv =====
// Shared constants and types for the one-shot timer list and paced queue.
`default_nettype none
package otlpq_pkg;
  localparam int TIMER_SLOTS = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int TW = $clog2(TIMER_SLOTS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam logic [47:0] MAX48 = '1;
  localparam logic [5:0] FIRES_RESET = 6'd50;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TIMER = 2'd1,
    OP_QUEUE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TIMER  = 2'd0,
    KIND_QUEUE  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_QUEUE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [47:0] deadline;
    logic [15:0] ident;
  } timer_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic        load;
    logic        shift;
    logic [TW:0] load_idx;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/oneshot_timer_list_and_paced_queue_top.sv =====
// Top level: timer chain, paced queue RAM and sequencer.
// Usage: pulse start_i with op/delta/length/job_id while busy_o is low.
// Results come out on kind_o/fired_id_o/last_o, each for one cycle, marked by
// valid_o; the receiver cannot stall them. cfg_we_i/cfg_data_i write
// max_fires_per_tick (reset 50); the user must write it only while idle, as
// the block does not enforce this. Adds and clear keep busy_o low; a reject
// shows its word in the cycle after the accepting edge.
// A tick walks the T stored timers, one per cycle: the head cell is tested,
// then dropped (fired) or reinserted after the live ones, while the whole
// chain shifts down by one. Then the ST_QUEUE state decides the queue release
// and ST_EMIT flushes the held word with last set. Each word is held in a
// pending register so that the final one can carry last; the last word shows
// in the same cycle that busy_o falls.
// Reset clears the counts, elapsed time and pacing; stores need no clearing.
`default_nettype none
module oneshot_timer_list_and_paced_queue_top import otlpq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] delta_i,
  input  wire logic [31:0] length_i,
  input  wire logic [15:0] job_id_i,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_data_i,
  output      logic        valid_o,
  output      logic [1:0]  kind_o,
  output      logic [15:0] fired_id_o,
  output      logic        last_o
);
  state_e state_q, state_d;
  logic [5:0]  fires_max_q;
  logic [47:0] elapsed_q, elapsed_d;
  logic [TW:0] tcount_q, tcount_d, left_q, left_d;
  logic [5:0]  fired_q, fired_d;
  logic [QW-1:0] qhead_q, qhead_d;
  logic [QW:0]   qcount_q, qcount_d;
  logic [31:0] since_q, since_d, cur_q, cur_d, since_sat;
  logic [15:0] delta_q;
  logic        pend_q, pend_d;
  logic [1:0]  pkind_q, pkind_d;
  logic [15:0] pid_q, pid_d;
  logic        valid_q, valid_d, last_q, last_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] id_q, id_d;
  logic        accept;
  logic        fire;
  cell_ctl_t   ctl;
  timer_t      newt;
  timer_t      cells [TIMER_SLOTS];
  logic        qwe;
  logic [QW-1:0] qwaddr;
  logic [47:0] qrdata;
  logic [48:0] esum;
  logic [48:0] dsum;
  logic [32:0] ssum;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Cell chain: cell i takes cell i+1 on a shift.
  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    timer_t nxt;
    if (g == TIMER_SLOTS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cells[g + 1];
    end
    otlpq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .my_idx_i((TW+1)'(g)),
      .new_i   (newt),
      .next_i  (nxt),
      .val_o   (cells[g])
    );
  end

  assign esum = {1'b0, elapsed_q} + {33'd0, delta_i};
  assign dsum = {1'b0, elapsed_q} + {17'd0, length_i};

  otlpq_ram #(.Width(48), .Depth(QUEUE_DEPTH)) u_qram (
    .clk_i  (clk_i),
    .we_i   (qwe),
    .waddr_i(qwaddr),
    .wdata_i({length_i, job_id_i}),
    .raddr_i(qhead_q),
    .rdata_o(qrdata)
  );
  assign qwaddr = qhead_q + qcount_q[QW-1:0];
  assign qwe = accept && op_e'(op_i) == OP_QUEUE && !qcount_q[QW];
  assign ssum = {1'b0, since_q} + {17'd0, delta_q};
  assign since_sat = ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
  assign fire = (fired_q < fires_max_q) && (elapsed_q >= cells[0].deadline);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && op_e'(op_i) == OP_TICK) begin
        state_d = ST_SCAN;
      end
      ST_SCAN: if (left_q == '0) begin
        state_d = ST_QUEUE;
      end
      ST_QUEUE: state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    elapsed_d = elapsed_q;
    tcount_d = tcount_q;
    left_d = left_q;
    fired_d = fired_q;
    qhead_d = qhead_q;
    qcount_d = qcount_q;
    since_d = since_q;
    cur_d = cur_q;
    pend_d = pend_q;
    pkind_d = pkind_q;
    pid_d = pid_q;
    valid_d = 1'b0;
    last_d = 1'b0;
    kind_d = pkind_q;
    id_d = pid_q;
    ctl = '0;
    newt = '0;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        unique case (op_e'(op_i))
          OP_TICK: begin
            elapsed_d = esum[48] ? MAX48 : esum[47:0];
            left_d = tcount_q;
            fired_d = '0;
            pend_d = 1'b0;
          end
          OP_TIMER: begin
            if (tcount_q[TW]) begin
              valid_d = 1'b1; last_d = 1'b1; kind_d = KIND_REJECT; id_d = job_id_i;
            end else begin
              newt.deadline = dsum[48] ? MAX48 : dsum[47:0];
              newt.ident = job_id_i;
              ctl.load = 1'b1;
              ctl.load_idx = tcount_q;
              tcount_d = tcount_q + 1'b1;
            end
          end
          OP_QUEUE: begin
            if (qcount_q[QW]) begin
              valid_d = 1'b1; last_d = 1'b1; kind_d = KIND_REJECT; id_d = job_id_i;
            end else begin
              qcount_d = qcount_q + 1'b1;
            end
          end
          OP_CLEAR: begin
            elapsed_d = '0; tcount_d = '0; qhead_d = '0; qcount_d = '0;
            since_d = '0; cur_d = '0;
          end
          default: ;
        endcase
      end
      ST_SCAN: if (left_q != '0) begin
        // Chain shifts down; a kept head is reinserted after the live ones.
        ctl.shift = 1'b1;
        left_d = left_q - 1'b1;
        if (fire) begin
          valid_d = pend_q;
          pend_d = 1'b1;
          pkind_d = KIND_TIMER;
          pid_d = cells[0].ident;
          fired_d = fired_q + 1'b1;
          tcount_d = tcount_q - 1'b1;
        end else begin
          ctl.load = 1'b1;
          ctl.load_idx = tcount_q - 1'b1;
          newt = cells[0];
        end
      end
      ST_QUEUE: begin
        if (qcount_q != '0) begin
          since_d = since_sat;
          if (since_sat >= cur_q) begin
            since_d = '0;
            cur_d = qrdata[47:16];
            valid_d = pend_q;
            pend_d = 1'b1;
            pkind_d = KIND_QUEUE;
            pid_d = qrdata[15:0];
            qhead_d = qhead_q + 1'b1;
            qcount_d = qcount_q - 1'b1;
          end
        end else begin
          since_d = '0; cur_d = '0;
        end
      end
      ST_EMIT: begin
        valid_d = pend_q;
        last_d = pend_q;
        pend_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fires_max_q <= FIRES_RESET;
      elapsed_q <= '0; tcount_q <= '0; left_q <= '0; fired_q <= '0;
      qhead_q <= '0; qcount_q <= '0; since_q <= '0; cur_q <= '0;
      pend_q <= 1'b0; pkind_q <= KIND_TIMER; pid_q <= '0; delta_q <= '0;
      valid_q <= 1'b0; last_q <= 1'b0; kind_q <= KIND_TIMER; id_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fires_max_q <= cfg_data_i;
      end
      if (accept) begin
        delta_q <= delta_i;
      end
      elapsed_q <= elapsed_d; tcount_q <= tcount_d; left_q <= left_d;
      fired_q <= fired_d; qhead_q <= qhead_d;
      qcount_q <= qcount_d; since_q <= since_d; cur_q <= cur_d;
      pend_q <= pend_d; pkind_q <= pkind_d; pid_q <= pid_d;
      valid_q <= valid_d; last_q <= last_d; kind_q <= kind_d; id_q <= id_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o = kind_q;
  assign fired_id_o = id_q;
  assign last_o = last_q;

  a_tcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= (TW+1)'(TIMER_SLOTS));
  a_qcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= (QW+1)'(QUEUE_DEPTH));
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> valid_q);
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (kind_q == KIND_TIMER || kind_q == KIND_QUEUE || kind_q == KIND_REJECT));
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q);
endmodule
`default_nettype wire

// ===== hw/rtl/otlpq_cell.sv =====
// One timer slot of the shifting timer chain.
`default_nettype none
module otlpq_cell import otlpq_pkg::*; (
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire logic [TW:0] my_idx_i,
  input  wire timer_t    new_i,
  input  wire timer_t    next_i,
  output      timer_t    val_o
);
  timer_t val_q, val_d;
  always_comb begin
    val_d = val_q;
    if (ctl_i.load && ctl_i.load_idx == my_idx_i) begin
      val_d = new_i;
    end else if (ctl_i.shift) begin
      val_d = next_i;
    end
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
  assign val_o = val_q;
endmodule
`default_nettype wire

// ===== hw/rtl/otlpq_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module otlpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== tb/oneshot_timer_list_and_paced_queue_top_tb.sv =====
// Testbench for the one-shot timer list and paced queue: directed and random checks.
`timescale 1ns / 1ps
module oneshot_timer_list_and_paced_queue_top_tb;
  import otlpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = TIMER_SLOTS + 8;
  localparam int EXP_DEPTH = 256;

  typedef struct {
    kind_e       kind;
    logic [15:0] ident;
    logic        last;
  } fire_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  op_i = '0;
  logic [15:0] delta_i = '0;
  logic [31:0] length_i = '0;
  logic [15:0] job_id_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_data_i = '0;
  logic        valid_o;
  logic [1:0]  kind_o;
  logic [15:0] fired_id_o;
  logic        last_o;

  oneshot_timer_list_and_paced_queue_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .delta_i, .length_i, .job_id_i,
    .cfg_we_i, .cfg_data_i, .valid_o, .kind_o, .fired_id_o, .last_o
  );

  always #2 clk_i = ~clk_i;

  // shadow state
  logic [5:0]  fire_limit;
  logic [47:0] now_ticks;
  logic [47:0] tmr_deadline [TIMER_SLOTS];
  logic [15:0] tmr_ident [TIMER_SLOTS];
  int          tmr_count;
  logic [31:0] q_interval [QUEUE_DEPTH];
  logic [15:0] q_ident [QUEUE_DEPTH];
  int          q_head, q_count;
  logic [31:0] since_release, pace_interval;

  fire_word_t  exp_words [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  function automatic int exp_count();
    return exp_wr - exp_rd;
  endfunction

  function automatic void put_word(kind_e k, logic [15:0] id);
    fire_word_t w;
    w.kind = k;
    w.ident = id;
    w.last = 1'b0;
    exp_words[exp_wr % EXP_DEPTH] = w;
    exp_wr++;
  endfunction

  function automatic void clear_shadow();
    now_ticks = '0;
    tmr_count = 0;
    q_head = 0;
    q_count = 0;
    since_release = '0;
    pace_interval = '0;
  endfunction

  function automatic void predict_word(op_e op, logic [15:0] dl, logic [31:0] len,
                                       logic [15:0] id);
    int n0, keep, fired;
    logic [48:0] sum;
    logic [32:0] s32;
    n0 = exp_wr;
    case (op)
      OP_TICK: begin
        sum = {1'b0, now_ticks} + {33'd0, dl};
        now_ticks = sum[48] ? MAX48 : sum[47:0];
        keep = 0;
        fired = 0;
        for (int i = 0; i < tmr_count; i++) begin
          if (fired < fire_limit && now_ticks >= tmr_deadline[i]) begin
            put_word(KIND_TIMER, tmr_ident[i]);
            fired++;
          end else begin
            tmr_deadline[keep] = tmr_deadline[i];
            tmr_ident[keep] = tmr_ident[i];
            keep++;
          end
        end
        tmr_count = keep;
        if (q_count > 0) begin
          s32 = {1'b0, since_release} + {17'd0, dl};
          since_release = s32[32] ? '1 : s32[31:0];
          if (since_release >= pace_interval) begin
            since_release = '0;
            pace_interval = q_interval[q_head];
            put_word(KIND_QUEUE, q_ident[q_head]);
            q_head = (q_head + 1) % QUEUE_DEPTH;
            q_count--;
          end
        end else begin
          since_release = '0;
          pace_interval = '0;
        end
      end
      OP_TIMER: begin
        if (tmr_count >= TIMER_SLOTS) put_word(KIND_REJECT, id);
        else begin
          sum = {1'b0, now_ticks} + {17'd0, len};
          tmr_deadline[tmr_count] = sum[48] ? MAX48 : sum[47:0];
          tmr_ident[tmr_count] = id;
          tmr_count++;
        end
      end
      OP_QUEUE: begin
        if (q_count >= QUEUE_DEPTH) put_word(KIND_REJECT, id);
        else begin
          q_interval[(q_head + q_count) % QUEUE_DEPTH] = len;
          q_ident[(q_head + q_count) % QUEUE_DEPTH] = id;
          q_count++;
        end
      end
      default: clear_shadow();
    endcase
    if (exp_wr > n0) exp_words[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    fire_word_t w;
    if (rst_ni && valid_o) begin
      if (exp_count() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word kind=%0d id=%h last=%b",
                                   kind_o, fired_id_o, last_o);
      end else begin
        w = exp_words[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (kind_o !== w.kind || fired_id_o !== w.ident || last_o !== w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind=%0d id=%h last=%b, got kind=%0d id=%h last=%b",
                     w.kind, w.ident, w.last, kind_o, fired_id_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("oneshot_timer_list_and_paced_queue_top_tb: errors");
      $finish;
    end
  end

  task automatic send_word(op_e op, logic [15:0] dl, logic [31:0] len, logic [15:0] id);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    op_i     <= op;
    delta_i  <= dl;
    length_i <= len;
    job_id_i <= id;
    do @(posedge clk_i); while (busy_o);
    predict_word(op, dl, len, id);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (exp_count() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_fire_limit(logic [5:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fire_limit = v;
  endtask

  task automatic test_timer_store();
    send_word(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_word(OP_TIMER, '0, (i == 1) ? 32'hFFFF_FFFF : i[31:0], 16'(i * 97));
    send_word(OP_TIMER, '0, 32'd5, 16'hFFFF);
    send_word(OP_TICK, 16'd0, '0, '0);
    send_word(OP_TICK, 16'hFFFF, '0, '0);
    send_word(OP_TICK, 16'hFFFF, '0, '0);
  endtask

  task automatic test_queue_pacing();
    send_word(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_word(OP_QUEUE, '0, (i == 0) ? 32'hFFFF_FFFF : 32'(i % 3 * 4), 16'(i + 16'h100));
    send_word(OP_QUEUE, '0, '0, 16'h0000);
    for (int i = 0; i < 24; i++) send_word(OP_TICK, 16'(i % 5), '0, '0);
    send_word(OP_TICK, 16'hFFFF, '0, '0);
    for (int i = 0; i < 24; i++) send_word(OP_TICK, 16'd6, '0, '0);
  endtask

  task automatic test_fire_limit();
    logic [5:0] lims [3] = '{6'd0, 6'd1, 6'd63};
    foreach (lims[k]) begin
      set_fire_limit(lims[k]);
      send_word(OP_CLEAR, '0, '0, '0);
      for (int i = 0; i < 6; i++) send_word(OP_TIMER, '0, 32'd2, 16'(i));
      send_word(OP_QUEUE, '0, 32'd1, 16'hBEEF);
      send_word(OP_TICK, 16'd3, '0, '0);
      send_word(OP_TICK, 16'd3, '0, '0);
    end
  endtask

  task automatic random_word();
    int r;
    logic [15:0] dl;
    logic [31:0] len;
    r = $urandom_range(99);
    dl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    case ($urandom_range(4))
      0: len = $urandom;
      1: len = $urandom_range(0, 5000);
      default: len = $urandom_range(0, 200);
    endcase
    if (r < 42) send_word(OP_TICK, dl, '0, '0);
    else if (r < 72) send_word(OP_TIMER, '0, len, 16'($urandom));
    else if (r < 97) send_word(OP_QUEUE, '0, len[31:0] >> $urandom_range(0, 24),
                               16'($urandom));
    else send_word(OP_CLEAR, '0, '0, '0);
  endtask

  task automatic test_random();
    int pcts [5] = '{0, 68, 0, 31, 68};
    logic [5:0] lims [5] = '{6'd50, 6'd1, 6'd63, 6'd7, 6'd2};
    foreach (pcts[p]) begin
      set_fire_limit(lims[p]);
      idle_pct = pcts[p];
      for (int i = 0; i < 67; i++) begin
        random_word();
        if (p == 2 && i == 40) drain();
      end
    end
  endtask

  initial begin
    fire_limit = FIRES_RESET;
    clear_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_timer_store();
    test_queue_pacing();
    test_fire_limit();
    test_random();
    drain();
    if (errors == 0 && exp_count() == 0)
      $display("oneshot_timer_list_and_paced_queue_top_tb: clean");
    else
      $display("oneshot_timer_list_and_paced_queue_top_tb: errors");
    $finish;
  end
endmodule
